### rtl/core/rama_pkg.sv
// ----------------------------------------------------------------------------
// rama_pkg
// shared types and constants for the rational add/multiply/reduce block
// ----------------------------------------------------------------------------
`default_nettype none

package rama_pkg;

	localparam int RES_W = 33;

	typedef enum logic [1:0] {
		KIND_ADD = 2'd0,
		KIND_MUL = 2'd1,
		KIND_INC = 2'd2,
		KIND_CMP = 2'd3
	} kind_t;

	typedef enum logic {
		UOP_MUL = 1'b0,
		UOP_DIV = 1'b1
	} uop_t;

	typedef struct packed {
		logic start;
		uop_t op;
	} unit_req_t;

endpackage

`default_nettype wire

### rtl/core/rama_unit.sv
// ----------------------------------------------------------------------------
// rama_unit
// shared iterative unit: shift-add multiply or restoring divide, one bit a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module rama_unit import rama_pkg::*; #(
	parameter int MW   = 33,
	parameter int MULN = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire unit_req_t     req,
	input  wire logic [MW-1:0] opa,
	input  wire logic [MW-1:0] opb,
	output logic               done,
	output logic [MW-1:0]      quo,
	output logic [MW-1:0]      rem
);

	localparam int CW = $clog2(MW + 1);

	logic          busy_q;
	logic          done_q;
	uop_t          op_q;
	logic [CW-1:0] cnt_q;
	logic [MW-1:0] acc_q;
	logic [MW-1:0] a_q;
	logic [MW-1:0] b_q;

	logic [MW:0]   sh;
	logic [MW:0]   add_a;
	logic [MW:0]   add_b;
	logic [MW+1:0] sum;
	logic          ge;

	always_comb begin
		sh = {acc_q, b_q[MW-1]};
		if (op_q == UOP_DIV) begin
			add_a = sh;
			add_b = ~{1'b0, a_q};
		end else begin
			add_a = {1'b0, acc_q};
			add_b = {1'b0, a_q};
		end
		sum = {1'b0, add_a} + {1'b0, add_b} + {{(MW+1){1'b0}}, op_q == UOP_DIV};
		ge  = sum[MW+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= UOP_MUL;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start && !busy_q) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				cnt_q  <= (req.op == UOP_DIV) ? CW'(MW) : CW'(MULN);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start && !busy_q) begin
			acc_q <= '0;
			if (req.op == UOP_DIV) begin
				a_q <= opb;
				b_q <= opa;
			end else begin
				a_q <= opa;
				b_q <= opb;
			end
		end else if (busy_q) begin
			if (op_q == UOP_DIV) begin
				acc_q <= ge ? sum[MW-1:0] : sh[MW-1:0];
				b_q   <= {b_q[MW-2:0], ge};
			end else begin
				if (b_q[0]) begin
					acc_q <= sum[MW-1:0];
				end
				a_q <= {a_q[MW-2:0], 1'b0};
				b_q <= {1'b0, b_q[MW-1:1]};
			end
		end
	end

	assign done = done_q;
	assign quo  = (op_q == UOP_DIV) ? b_q : acc_q;
	assign rem  = acc_q;

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("unit done held for two cycles");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && cnt_q != CW'(1)) |=> busy_q)
		else $error("unit stopped early");
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && op_q == UOP_DIV) |-> (acc_q < a_q))
		else $error("remainder not below divisor");

endmodule

`default_nettype wire

### rtl/core/rational_add_mul_reduce.sv
// ----------------------------------------------------------------------------
// rational_add_mul_reduce
// exact add, multiply or increment of signed fractions, reduced by euclid gcd
// ----------------------------------------------------------------------------
// input channel in_valid/in_stall carries kind and the two fractions; output
// channel out_valid/out_stall carries res_num, res_den, is_equal, zero_divisor.
// a beat is taken when valid is high and stall is low.
// one item at a time: in_stall is high from acceptance until the result is
// loaded into the output register. magnitudes take M = 2*W+1 bits, with
// W = OPERAND_WIDTH. an add runs three multiplies, the add, a division per
// euclid step and a division of both terms by the gcd; a multiply runs two
// multiplies, an increment none, and a compare of the fields for equality
// goes straight to the output. the cost is set by the shared unit, which
// multiplies one bit and divides one quotient bit a cycle. the output
// register holds a result while out_stall is high; the block takes the
// next item meanwhile and waits at the end for the register.
// reset clears the sequencer and the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module rational_add_mul_reduce import rama_pkg::*; #(
	parameter int OPERAND_WIDTH = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [1:0]                      kind,
	input  wire logic signed [OPERAND_WIDTH-1:0] a_num,
	input  wire logic signed [OPERAND_WIDTH-1:0] a_den,
	input  wire logic signed [OPERAND_WIDTH-1:0] b_num,
	input  wire logic signed [OPERAND_WIDTH-1:0] b_den,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic signed [RES_W-1:0]              res_num,
	output logic signed [RES_W-1:0]              res_den,
	output logic                                 is_equal,
	output logic                                 zero_divisor
);

	localparam int W  = OPERAND_WIDTH;
	localparam int MW = 2 * W + 1;
	localparam int XW = (MW > RES_W) ? MW : RES_W;

	typedef enum logic [8:0] {
		S_IDLE = 9'b000000001,
		S_MUL1 = 9'b000000010,
		S_MUL2 = 9'b000000100,
		S_MUL3 = 9'b000001000,
		S_ADD  = 9'b000010000,
		S_GCD  = 9'b000100000,
		S_DIVN = 9'b001000000,
		S_DIVD = 9'b010000000,
		S_OUT  = 9'b100000000
	} state_t;

	function automatic logic [MW-1:0] load_mag(input logic [W-1:0] raw);
		logic [W-1:0] m;
		m = raw[W-1] ? (~raw + 1'b1) : raw;
		return MW'(m);
	endfunction

	function automatic logic [RES_W-1:0] to_res(input logic neg, input logic [MW-1:0] mag);
		logic [XW-1:0] ext;
		ext = XW'(mag);
		ext = neg ? (~ext + 1'b1) : ext;
		return ext[RES_W-1:0];
	endfunction

	state_t        state_q;
	logic          issued_q;
	kind_t         kind_q;
	logic          an_s_q, ad_s_q, bn_s_q, bd_s_q;
	logic [MW-1:0] an_m_q, ad_m_q, bn_m_q, bd_m_q;
	logic          t_s_q, u_s_q, num_s_q, den_s_q, x_s_q, y_s_q, rn_s_q, rd_s_q;
	logic [MW-1:0] t_m_q, u_m_q, num_m_q, den_m_q, x_m_q, y_m_q, rn_m_q, rd_m_q;
	logic          eq_q, zd_q;

	logic          out_valid_q;
	logic [RES_W-1:0] res_num_q, res_den_q;
	logic          is_equal_q, zero_divisor_q;

	unit_req_t     req;
	logic [MW-1:0] opa, opb;
	logic          u_done;
	logic [MW-1:0] u_quo, u_rem;
	logic          mul_s;
	logic          add_s;
	logic [MW-1:0] add_m;
	logic          busy_op;
	logic          out_free;

	rama_unit #(
		.MW   (MW),
		.MULN (W)
	) u_unit (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.opa    (opa),
		.opb    (opb),
		.done   (u_done),
		.quo    (u_quo),
		.rem    (u_rem)
	);

	always_comb begin
		opa   = an_m_q;
		opb   = bd_m_q;
		mul_s = an_s_q ^ bd_s_q;
		req.op = UOP_MUL;
		unique case (state_q)
			S_MUL1: begin
				if (kind_q == KIND_MUL) begin
					opb   = bn_m_q;
					mul_s = an_s_q ^ bn_s_q;
				end
			end
			S_MUL2: begin
				opa   = bn_m_q;
				opb   = ad_m_q;
				mul_s = bn_s_q ^ ad_s_q;
			end
			S_MUL3: begin
				opa   = ad_m_q;
				opb   = bd_m_q;
				mul_s = ad_s_q ^ bd_s_q;
			end
			S_GCD: begin
				opa    = x_m_q;
				opb    = y_m_q;
				req.op = UOP_DIV;
			end
			S_DIVN: begin
				opa    = num_m_q;
				opb    = x_m_q;
				req.op = UOP_DIV;
			end
			S_DIVD: begin
				opa    = den_m_q;
				opb    = x_m_q;
				req.op = UOP_DIV;
			end
			default: begin
			end
		endcase
		busy_op = (state_q == S_MUL1) || (state_q == S_MUL2) || (state_q == S_MUL3) ||
			(state_q == S_DIVN) || (state_q == S_DIVD) ||
			((state_q == S_GCD) && (y_m_q != '0));
		req.start = busy_op && !issued_q;
	end

	always_comb begin
		if (t_s_q == u_s_q) begin
			add_s = t_s_q;
			add_m = t_m_q + u_m_q;
		end else if (t_m_q >= u_m_q) begin
			add_s = t_s_q;
			add_m = t_m_q - u_m_q;
		end else begin
			add_s = u_s_q;
			add_m = u_m_q - t_m_q;
		end
		if (add_m == '0) begin
			add_s = 1'b0;
		end
	end

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			issued_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			if (req.start) begin
				issued_q <= 1'b1;
			end else if (u_done) begin
				issued_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						unique case (kind_t'(kind))
							KIND_ADD, KIND_MUL: state_q <= S_MUL1;
							KIND_INC: state_q <= S_ADD;
							KIND_CMP: state_q <= S_OUT;
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_MUL1: if (u_done) begin
					state_q <= (kind_q == KIND_ADD) ? S_MUL2 : S_MUL3;
				end
				S_MUL2: if (u_done) begin
					state_q <= S_MUL3;
				end
				S_MUL3: if (u_done) begin
					state_q <= S_ADD;
				end
				S_ADD: state_q <= S_GCD;
				S_GCD: begin
					if (y_m_q == '0) begin
						state_q <= (x_m_q == '0) ? S_OUT : S_DIVN;
					end
				end
				S_DIVN: if (u_done) begin
					state_q <= S_DIVD;
				end
				S_DIVD: if (u_done) begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					kind_q <= kind_t'(kind);
					an_s_q <= a_num[W-1];
					ad_s_q <= a_den[W-1];
					bn_s_q <= b_num[W-1];
					bd_s_q <= b_den[W-1];
					an_m_q <= load_mag(a_num);
					ad_m_q <= load_mag(a_den);
					bn_m_q <= load_mag(b_num);
					bd_m_q <= load_mag(b_den);
					t_s_q  <= a_num[W-1];
					t_m_q  <= load_mag(a_num);
					u_s_q  <= a_den[W-1];
					u_m_q  <= load_mag(a_den);
					den_s_q <= a_den[W-1];
					den_m_q <= load_mag(a_den);
					eq_q   <= (kind_t'(kind) == KIND_CMP) &&
						(a_num == b_num) && (a_den == b_den);
					zd_q   <= 1'b0;
					rn_s_q <= 1'b0;
					rn_m_q <= '0;
					rd_s_q <= 1'b0;
					rd_m_q <= '0;
				end
			end
			S_MUL1: if (u_done) begin
				t_s_q <= mul_s && (u_quo != '0);
				t_m_q <= u_quo;
				u_s_q <= 1'b0;
				u_m_q <= '0;
			end
			S_MUL2: if (u_done) begin
				u_s_q <= mul_s && (u_quo != '0);
				u_m_q <= u_quo;
			end
			S_MUL3: if (u_done) begin
				den_s_q <= mul_s && (u_quo != '0);
				den_m_q <= u_quo;
			end
			S_ADD: begin
				num_s_q <= add_s;
				num_m_q <= add_m;
				x_s_q   <= add_s;
				x_m_q   <= add_m;
				y_s_q   <= den_s_q;
				y_m_q   <= den_m_q;
			end
			S_GCD: begin
				if (y_m_q == '0) begin
					if (x_m_q == '0) begin
						zd_q   <= 1'b1;
						rn_s_q <= num_s_q;
						rn_m_q <= num_m_q;
						rd_s_q <= den_s_q;
						rd_m_q <= den_m_q;
					end
				end else if (u_done) begin
					x_s_q <= y_s_q;
					x_m_q <= y_m_q;
					y_s_q <= x_s_q && (u_rem != '0);
					y_m_q <= u_rem;
				end
			end
			S_DIVN: if (u_done) begin
				rn_s_q <= (num_s_q ^ x_s_q) && (u_quo != '0);
				rn_m_q <= u_quo;
			end
			S_DIVD: if (u_done) begin
				rd_s_q <= (den_s_q ^ x_s_q) && (u_quo != '0);
				rd_m_q <= u_quo;
			end
			S_OUT: begin
				if (out_free) begin
					res_num_q      <= to_res(rn_s_q, rn_m_q);
					res_den_q      <= to_res(rd_s_q, rd_m_q);
					is_equal_q     <= eq_q;
					zero_divisor_q <= zd_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign in_stall     = (state_q != S_IDLE);
	assign out_valid    = out_valid_q;
	assign res_num      = res_num_q;
	assign res_den      = res_den_q;
	assign is_equal     = is_equal_q;
	assign zero_divisor = zero_divisor_q;

	a_zd_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && zero_divisor) |-> (res_num == '0 && res_den == '0 && !is_equal))
		else $error("zero gcd beat with nonzero fields");
	a_eq_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_equal) |-> (res_num == '0 && res_den == '0))
		else $error("compare beat with nonzero fields");
	a_done_in_op: assert property (@(posedge clk) disable iff (!arst_n)
		u_done |-> (issued_q && state_q != S_IDLE && state_q != S_OUT))
		else $error("unit result with no operation pending");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && !out_free) |=> (state_q == S_OUT))
		else $error("result left the sequencer while output busy");

endmodule

`default_nettype wire
